/* rtl/ackf_pkg.sv */
package ackf_pkg;

  // input commands as they arrive on the port
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // classified operations handed to the frame engine
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TIMEOUT    = 3'd1;
  localparam logic [2:0] ST_BAD_ACK    = 3'd2;
  localparam logic [2:0] ST_BAD_HEADER = 3'd3;
  localparam logic [2:0] ST_BAD_LCS    = 3'd4;
  localparam logic [2:0] ST_TOO_LONG   = 3'd5;
  localparam logic [2:0] ST_BAD_DCS    = 3'd6;
  localparam logic [2:0] ST_BAD_POST   = 3'd7;

  // configuration register indexes
  localparam logic [7:0] REG_TIMEOUT  = 8'd0;
  localparam logic [7:0] REG_CAPACITY = 8'd1;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
  localparam logic [7:0]  CAPACITY_RESET = 8'd32;

  localparam logic [2:0] ACK_LEN = 3'd6;
  localparam logic [2:0] HDR_LEN = 3'd5;
  localparam logic [7:0] MIN_LEN = 8'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  payload_capacity;
  } cfg_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [7:0] frame_length;
  } res_t;

  // ack is 00 00 FF 00 FF 00
  function automatic logic [7:0] ack_byte(input logic [2:0] pos);
    ack_byte = (pos == 3'd2 || pos == 3'd4) ? 8'hFF : 8'h00;
  endfunction

  // header preamble is 00 00 FF
  function automatic logic [7:0] pre_byte(input logic [1:0] pos);
    pre_byte = (pos == 2'd2) ? 8'hFF : 8'h00;
  endfunction

endpackage

/* rtl/ackf_front.sv */
module ackf_front
  import ackf_pkg::*;
(
  input  logic       in_valid,
  input  logic [1:0] cmd,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output q_item_t    item
);

  logic known;

  assign in_stall = q_full;

  // unused command code is accepted and dropped here
  always_comb begin
    known = 1'b1;
    item.data = rx_byte;
    case (cmd)
      CMD_START: item.op = OP_START;
      CMD_BYTE:  item.op = OP_BYTE;
      CMD_TICK:  item.op = OP_TICK;
      default: begin
        item.op = OP_TICK;
        known = 1'b0;
      end
    endcase
  end

  assign push = in_valid && !q_full && known;

endmodule

/* rtl/ackf_fifo.sv */
module ackf_fifo
  import ackf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t wr_item,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output q_item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  q_item_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/ackf_back.sv */
module ackf_back
  import ackf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    pop,
  input  logic    out_stall,
  output logic    out_valid,
  output res_t    res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ACK     = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_DCS     = 3'd4;
  localparam logic [2:0] PH_POST    = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  held_checksum, held_checksum_next;
  logic        pattern_mismatch, pattern_mismatch_next;
  logic [15:0] ticks_left, ticks_left_next;

  logic        hit;
  res_t        res_next;
  logic [7:0]  b;
  logic [7:0]  pos_inc;
  logic        mis_ack;
  logic        mis_pre;

  // take a word when the output slot is empty or draining this cycle
  assign pop = q_valid && (!out_valid || !out_stall);

  assign b       = q_item.data;
  assign pos_inc = byte_position + 8'd1;
  assign mis_ack = pattern_mismatch || (b != ack_byte(byte_position[2:0]));
  assign mis_pre = pattern_mismatch || (b != pre_byte(byte_position[1:0]));

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    expected_length_next  = expected_length;
    running_sum_next      = running_sum;
    held_checksum_next    = held_checksum;
    pattern_mismatch_next = pattern_mismatch;
    ticks_left_next       = ticks_left;
    hit                   = 1'b0;
    res_next              = '0;

    case (q_item.op)
      OP_START: begin
        phase_next            = PH_ACK;
        byte_position_next    = '0;
        expected_length_next  = '0;
        running_sum_next      = '0;
        held_checksum_next    = '0;
        pattern_mismatch_next = 1'b0;
        ticks_left_next       = cfg.timeout_ticks;
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (ticks_left <= 16'd1) begin
            ticks_left_next    = '0;
            phase_next         = PH_IDLE;
            hit                = 1'b1;
            res_next.is_status = 1'b1;
            res_next.status    = ST_TIMEOUT;
          end else begin
            ticks_left_next = ticks_left - 16'd1;
          end
        end
      end
      OP_BYTE: begin
        case (phase)
          PH_ACK: begin
            pattern_mismatch_next = mis_ack;
            byte_position_next    = pos_inc;
            if (pos_inc >= {5'd0, ACK_LEN}) begin
              if (mis_ack) begin
                phase_next         = PH_IDLE;
                hit                = 1'b1;
                res_next.is_status = 1'b1;
                res_next.status    = ST_BAD_ACK;
              end else begin
                phase_next            = PH_HEADER;
                byte_position_next    = '0;
                pattern_mismatch_next = 1'b0;
              end
            end
          end
          PH_HEADER: begin
            byte_position_next = pos_inc;
            if (byte_position < 8'd3) begin
              pattern_mismatch_next = mis_pre;
            end else if (byte_position == 8'd3) begin
              expected_length_next = b;
            end else begin
              held_checksum_next = b;
            end
            // LCS is the last header byte, judged with it in hand
            if (pos_inc >= {5'd0, HDR_LEN}) begin
              if (pattern_mismatch) begin
                phase_next         = PH_IDLE;
                hit                = 1'b1;
                res_next.is_status = 1'b1;
                res_next.status    = ST_BAD_HEADER;
              end else if ((expected_length + b) != 8'd0 || expected_length < MIN_LEN) begin
                phase_next         = PH_IDLE;
                hit                = 1'b1;
                res_next.is_status = 1'b1;
                res_next.status    = ST_BAD_LCS;
              end else if (expected_length > cfg.payload_capacity) begin
                phase_next         = PH_IDLE;
                hit                = 1'b1;
                res_next.is_status = 1'b1;
                res_next.status    = ST_TOO_LONG;
              end else begin
                phase_next         = PH_PAYLOAD;
                byte_position_next = '0;
                running_sum_next   = '0;
              end
            end
          end
          PH_PAYLOAD: begin
            running_sum_next      = running_sum + b;
            byte_position_next    = pos_inc;
            if (pos_inc >= expected_length) begin
              phase_next = PH_DCS;
            end
            hit                   = 1'b1;
            res_next.payload_byte = b;
          end
          PH_DCS: begin
            held_checksum_next = b;
            phase_next         = PH_POST;
          end
          PH_POST: begin
            phase_next         = PH_IDLE;
            hit                = 1'b1;
            res_next.is_status = 1'b1;
            if ((running_sum + held_checksum) != 8'd0) begin
              res_next.status = ST_BAD_DCS;
            end else if (b != 8'd0) begin
              res_next.status = ST_BAD_POST;
            end else begin
              res_next.status       = ST_OK;
              res_next.frame_length = expected_length;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_position    <= '0;
      expected_length  <= '0;
      running_sum      <= '0;
      held_checksum    <= '0;
      pattern_mismatch <= 1'b0;
      ticks_left       <= '0;
    end else if (pop) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      expected_length  <= expected_length_next;
      running_sum      <= running_sum_next;
      held_checksum    <= held_checksum_next;
      pattern_mismatch <= pattern_mismatch_next;
      ticks_left       <= ticks_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= pop && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && hit) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/ack_and_checksummed_frame_receiver.sv */
// Reply deframer for one command exchange with an NFC controller. A start
// word opens an exchange; byte words must then bring the ack 00 00 FF 00 FF 00,
// the header 00 00 FF LEN LCS, LEN payload bytes, the data checksum and a zero
// postamble, and tick words count down timeout_ticks. Each payload byte comes
// out as its own word, and one status word (ok with frame_length, timeout or
// the first error) closes the exchange; bytes and ticks outside an exchange,
// and command code 3, are dropped. The block takes one input word per clock
// while in_stall is low. An accepted word is written into the input queue
// (QDEPTH words); the frame engine judges it as it leaves, and its result is
// registered in the output register. in_stall rises only when the queue is
// full, which for QDEPTH above 1 happens when out_stall holds the output
// register and the queue behind it has filled. Configuration writes are always
// ready and must be made while no exchange is in flight; indexes other than
// 0 (timeout_ticks) and 1 (payload_capacity) are ignored.
module ack_and_checksummed_frame_receiver
  import ackf_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_status,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status,
  output logic [7:0]  frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  q_item_t front_item;
  q_item_t q_item;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;
  res_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks    <= TIMEOUT_RESET;
      cfg.payload_capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TIMEOUT) begin
        cfg.timeout_ticks <= cfg_data;
      end else if (cfg_index == REG_CAPACITY) begin
        cfg.payload_capacity <= cfg_data[7:0];
      end
    end
  end

  ackf_front u_front (
    .in_valid (in_valid),
    .cmd      (cmd),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .item     (front_item)
  );

  ackf_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (front_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_item   (q_item)
  );

  ackf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign is_status    = res.is_status;
  assign payload_byte = res.payload_byte;
  assign status       = res.status;
  assign frame_length = res.frame_length;

  // engine never takes a word from an empty queue
  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("engine popped an empty queue");

  // frame length only travels with an ok status word
  a_len_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_length != 8'd0) |-> (is_status && status == ST_OK))
    else $error("frame length outside ok status");

  // a payload word carries no status code
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_status) |-> (status == ST_OK && frame_length == 8'd0))
    else $error("payload word carries status bits");

  // a held output word blocks the engine
  a_no_pop_when_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("engine advanced while output held");

endmodule
